// ===== rtl/core/sps_pkg.sv =====
package sps_pkg;

    localparam int TRIG_ITERATIONS_DEF = 16;
    localparam int TRIG_ITERATIONS_MAX = 30;

    localparam int LCG_MUL     = 1103515245;
    localparam int LCG_INC     = 12345;
    localparam int MINOR_MUL   = 858993459;   // 0.2 * 2^32
    localparam int CORDIC_GAIN = 652032874;   // 1/K in Q2.30

    // shape codes
    localparam logic [2:0] MODE_SPHERE   = 3'd0;
    localparam logic [2:0] MODE_CYLINDER = 3'd1;
    localparam logic [2:0] MODE_CONE     = 3'd2;
    localparam logic [2:0] MODE_INV_CONE = 3'd3;
    localparam logic [2:0] MODE_HEMI     = 3'd4;
    localparam logic [2:0] MODE_TORUS    = 3'd5;

    // register indexes
    localparam logic [2:0] REG_SHAPE_MODE  = 3'd0;
    localparam logic [2:0] REG_WIDTH       = 3'd1;
    localparam logic [2:0] REG_HEIGHT      = 3'd2;
    localparam logic [2:0] REG_CENTER_X    = 3'd3;
    localparam logic [2:0] REG_CENTER_Y    = 3'd4;
    localparam logic [2:0] REG_CENTER_Z    = 3'd5;
    localparam logic [2:0] REG_POINT_COUNT = 3'd6;

    typedef enum logic [1:0] {
        SH_BALL,
        SH_CYL,
        SH_CONE,
        SH_TORUS
    } t_shape;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DR_MUL,
        S_DR_ST,
        S_B_SQ0,
        S_B_SQ1,
        S_B_SQ2,
        S_B_ACC,
        S_B_CHK,
        S_B_W0,
        S_B_W1,
        S_B_W2,
        S_B_W3,
        S_K_START,
        S_K_H,
        S_K_WAIT,
        S_K_R,
        S_K_RAD,
        S_T_C2,
        S_T_M,
        S_T_W1,
        S_T_R,
        S_T_RG,
        S_T_OZ,
        S_T_W2,
        S_P_X,
        S_P_Y,
        S_P_E,
        S_FIN
    } t_state;

    // multiplier operand pairs
    typedef enum logic [3:0] {
        MOP_NONE,
        MOP_LCG,
        MOP_SQ,
        MOP_CW,
        MOP_HH,
        MOP_FW,
        MOP_RW,
        MOP_SR,
        MOP_MW,
        MOP_MC2,
        MOP_RC1,
        MOP_RS1,
        MOP_MS2
    } t_mop;

    // product write-back targets
    typedef enum logic [3:0] {
        SOP_NONE,
        SOP_DRAW,
        SOP_ACC0,
        SOP_ACC,
        SOP_OB,
        SOP_RAD32,
        SOP_RAD31,
        SOP_MINOR,
        SOP_RING,
        SOP_OX,
        SOP_OY,
        SOP_OZ,
        SOP_OZH
    } t_sop;

    typedef struct packed {
        logic       load;
        t_mop       mop;
        logic [1:0] msel;
        t_sop       sop;
        logic [1:0] ssel;
        logic       sq_start;
        logic [1:0] sq_src;
        logic       cd_start;
        logic [1:0] cd_src;
        logic       cd_dst;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        t_shape shape;
        logic   ball_ok;
        logic   sq_busy;
        logic   cd_busy;
        logic   out_full;
    } t_stat;

    function automatic t_shape shape_of(input logic [2:0] mode);
        t_shape s;
        unique case (mode) inside
            MODE_CYLINDER:            s = SH_CYL;
            MODE_CONE, MODE_INV_CONE: s = SH_CONE;
            MODE_TORUS:               s = SH_TORUS;
            default:                  s = SH_BALL;
        endcase
        return s;
    endfunction

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10680862;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [36:0] v);
        logic [31:0] r;
        if (v > 37'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -37'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/sps_ctrl.sv =====
module sps_ctrl
    import sps_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_draws, n_draws;
    logic       accept;
    logic       is_cyl;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign is_cyl  = (i_stat.shape == SH_CYL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_draws <= 2'd0;
        end else begin
            r_state <= n_state;
            r_draws <= n_draws;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_draws = r_draws;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DR_MUL;
                    n_draws = (i_stat.shape == SH_TORUS) ? 2'd2 : 2'd3;
                end
            end
            S_DR_MUL: n_state = S_DR_ST;
            S_DR_ST: begin
                if (r_draws == 2'd1) begin
                    unique case (i_stat.shape)
                        SH_BALL:  n_state = S_B_SQ0;
                        SH_TORUS: n_state = S_T_C2;
                        default:  n_state = S_K_START;
                    endcase
                end else begin
                    n_state = S_DR_MUL;
                end
                n_draws = r_draws - 2'd1;
            end
            S_B_SQ0: n_state = S_B_SQ1;
            S_B_SQ1: n_state = S_B_SQ2;
            S_B_SQ2: n_state = S_B_ACC;
            S_B_ACC: n_state = S_B_CHK;
            S_B_CHK: begin
                if (i_stat.ball_ok) begin
                    n_state = S_B_W0;
                end else begin
                    n_state = S_DR_MUL;
                    n_draws = 2'd3;
                end
            end
            S_B_W0: n_state = S_B_W1;
            S_B_W1: n_state = S_B_W2;
            S_B_W2: n_state = S_B_W3;
            S_B_W3: n_state = S_FIN;
            S_K_START: n_state = S_K_H;
            S_K_H:     n_state = S_K_WAIT;
            S_K_WAIT: begin
                if (!i_stat.sq_busy && !i_stat.cd_busy) begin
                    n_state = S_K_R;
                end
            end
            S_K_R:   n_state = S_K_RAD;
            S_K_RAD: n_state = S_P_X;
            S_T_C2:  n_state = S_T_M;
            S_T_M:   n_state = S_T_W1;
            S_T_W1: begin
                if (!i_stat.cd_busy) begin
                    n_state = S_T_R;
                end
            end
            S_T_R:  n_state = S_T_RG;
            S_T_RG: n_state = S_T_OZ;
            S_T_OZ: n_state = S_T_W2;
            S_T_W2: begin
                if (!i_stat.cd_busy) begin
                    n_state = S_P_X;
                end
            end
            S_P_X: n_state = S_P_Y;
            S_P_Y: n_state = S_P_E;
            S_P_E: n_state = S_FIN;
            S_FIN: begin
                if (!i_stat.out_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:   o_cmd.load = accept;
            S_DR_MUL: o_cmd.mop = MOP_LCG;
            S_DR_ST:  o_cmd.sop = SOP_DRAW;
            S_B_SQ0: begin
                o_cmd.mop  = MOP_SQ;
                o_cmd.msel = 2'd0;
            end
            S_B_SQ1: begin
                o_cmd.mop  = MOP_SQ;
                o_cmd.msel = 2'd1;
                o_cmd.sop  = SOP_ACC0;
            end
            S_B_SQ2: begin
                o_cmd.mop  = MOP_SQ;
                o_cmd.msel = 2'd2;
                o_cmd.sop  = SOP_ACC;
            end
            S_B_ACC: o_cmd.sop = SOP_ACC;
            S_B_CHK: o_cmd.sop = SOP_NONE;
            S_B_W0: begin
                o_cmd.mop  = MOP_CW;
                o_cmd.msel = 2'd0;
            end
            S_B_W1: begin
                o_cmd.mop  = MOP_CW;
                o_cmd.msel = 2'd1;
                o_cmd.sop  = SOP_OB;
                o_cmd.ssel = 2'd0;
            end
            S_B_W2: begin
                o_cmd.mop  = MOP_CW;
                o_cmd.msel = 2'd2;
                o_cmd.sop  = SOP_OB;
                o_cmd.ssel = 2'd1;
            end
            S_B_W3: begin
                o_cmd.sop  = SOP_OB;
                o_cmd.ssel = 2'd2;
            end
            S_K_START: begin
                o_cmd.mop      = MOP_FW;
                o_cmd.sq_start = 1'b1;
                o_cmd.sq_src   = is_cyl ? 2'd1 : 2'd2;
                o_cmd.cd_start = 1'b1;
                o_cmd.cd_src   = is_cyl ? 2'd0 : 2'd1;
                o_cmd.cd_dst   = 1'b0;
            end
            S_K_H: begin
                o_cmd.sop  = SOP_RAD32;
                o_cmd.mop  = MOP_HH;
                o_cmd.msel = is_cyl ? 2'd2 : 2'd0;
            end
            S_K_WAIT: o_cmd.sop = SOP_OZH;
            S_K_R:    o_cmd.mop = is_cyl ? MOP_RW : MOP_SR;
            S_K_RAD:  o_cmd.sop = is_cyl ? SOP_RAD32 : SOP_RAD31;
            S_T_C2: begin
                o_cmd.mop      = MOP_MW;
                o_cmd.cd_start = 1'b1;
                o_cmd.cd_src   = 2'd2;
                o_cmd.cd_dst   = 1'b1;
            end
            S_T_M:  o_cmd.sop = SOP_MINOR;
            S_T_W1: o_cmd.sop = SOP_NONE;
            S_T_R:  o_cmd.mop = MOP_MC2;
            S_T_RG: begin
                o_cmd.sop      = SOP_RING;
                o_cmd.mop      = MOP_MS2;
                o_cmd.cd_start = 1'b1;
                o_cmd.cd_src   = 2'd1;
                o_cmd.cd_dst   = 1'b0;
            end
            S_T_OZ: o_cmd.sop = SOP_OZ;
            S_T_W2: o_cmd.sop = SOP_NONE;
            S_P_X:  o_cmd.mop = MOP_RC1;
            S_P_Y: begin
                o_cmd.sop = SOP_OX;
                o_cmd.mop = MOP_RS1;
            end
            S_P_E: o_cmd.sop = SOP_OY;
            S_FIN: o_cmd.finish = !i_stat.out_full;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/sps_dp.sv =====
module sps_dp
    import sps_pkg::*;
#(
    parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_restart,
    input  logic [30:0] i_seed,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_x,
    output logic [31:0] o_y,
    output logic [31:0] o_z,
    output logic        o_last
);

    localparam int CntW = (TRIG_ITERATIONS > 1) ? $clog2(TRIG_ITERATIONS) : 1;

    // config
    logic [2:0]  r_mode;
    logic [31:0] r_width, r_height, r_cen_x, r_cen_y, r_cen_z;
    logic [15:0] r_count;

    // generator, draws, index
    logic [30:0] r_gen, n_gen;
    logic [30:0] r_d0, r_d1, r_d2;
    logic [15:0] r_idx;

    // arithmetic
    logic signed [67:0] r_prod;
    logic signed [33:0] mul_a, mul_b;
    logic [63:0]        r_acc;
    logic signed [33:0] r_rad, r_minor;
    logic signed [35:0] r_ox, r_oy, r_oz;
    logic signed [35:0] oz_h;

    // square root
    logic [63:0] r_sq_n, r_sq_res, r_sq_bit, sq_try;

    // cordic
    logic signed [33:0] r_cx, r_cy, r_cz, n_cx, n_cy, n_cz, dx, dy, atan;
    logic [CntW-1:0]    r_cd_cnt;
    logic               r_cd_busy, r_cd_dst;
    logic [1:0]         r_quad;
    logic signed [33:0] r_c1, r_s1, r_c2, r_s2, q_c, q_s;

    // output
    logic        r_valid, r_last;
    logic [31:0] r_px, r_py, r_pz;
    logic [16:0] idx_inc;
    logic        is_last;

    logic [30:0]        d_m, d_sq, d_cd;
    logic signed [33:0] c_m, c_z;
    logic [31:0]        frac;

    function automatic logic [30:0] pick(input logic [1:0] s, input logic [30:0] a,
                                        input logic [30:0] b, input logic [30:0] c);
        logic [30:0] r;
        case (s)
            2'd0:    r = a;
            2'd1:    r = b;
            default: r = c;
        endcase
        return r;
    endfunction

    assign d_m  = pick(i_cmd.msel, r_d0, r_d1, r_d2);
    assign d_sq = pick(i_cmd.sq_src, r_d0, r_d1, r_d2);
    assign d_cd = pick(i_cmd.cd_src, r_d0, r_d1, r_d2);
    // 2*u - 1 at scale 2^31
    assign c_m  = $signed({2'b00, d_m, 1'b0} - 34'h0_8000_0000);
    assign c_z  = $signed({2'b00, r_d2, 1'b0} - 34'h0_8000_0000);
    assign frac = (r_mode == MODE_CONE) ? (32'h8000_0000 - {1'b0, r_d0}) : {1'b0, r_d0};

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SPHERE;
            r_width  <= 32'd65536;
            r_height <= 32'd65536;
            r_cen_x  <= 32'd0;
            r_cen_y  <= 32'd0;
            r_cen_z  <= 32'd0;
            r_count  <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SHAPE_MODE:  r_mode   <= i_cfg_data[2:0];
                REG_WIDTH:       r_width  <= i_cfg_data;
                REG_HEIGHT:      r_height <= i_cfg_data;
                REG_CENTER_X:    r_cen_x  <= i_cfg_data;
                REG_CENTER_Y:    r_cen_y  <= i_cfg_data;
                REG_CENTER_Z:    r_cen_z  <= i_cfg_data;
                REG_POINT_COUNT: r_count  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mop)
            MOP_LCG: begin
                mul_a = {3'b000, r_gen};
                mul_b = 34'(LCG_MUL);
            end
            MOP_SQ: begin
                mul_a = c_m;
                mul_b = c_m;
            end
            MOP_CW: begin
                mul_a = c_m;
                mul_b = {2'b00, r_width};
            end
            MOP_HH: begin
                mul_a = {3'b000, d_m};
                mul_b = {2'b00, r_height};
            end
            MOP_FW: begin
                mul_a = {2'b00, frac};
                mul_b = {2'b00, r_width};
            end
            MOP_RW: begin
                mul_a = {3'b000, r_sq_res[30:0]};
                mul_b = {2'b00, r_width};
            end
            MOP_SR: begin
                mul_a = {3'b000, r_sq_res[30:0]};
                mul_b = r_rad;
            end
            MOP_MW: begin
                mul_a = {2'b00, r_width};
                mul_b = 34'(MINOR_MUL);
            end
            MOP_MC2: begin
                mul_a = r_minor;
                mul_b = r_c2;
            end
            MOP_RC1: begin
                mul_a = r_rad;
                mul_b = r_c1;
            end
            MOP_RS1: begin
                mul_a = r_rad;
                mul_b = r_s1;
            end
            MOP_MS2: begin
                mul_a = r_minor;
                mul_b = r_s2;
            end
            default: ;
        endcase
    end

    assign n_gen = r_prod[30:0] + 31'(LCG_INC);
    assign oz_h  = r_prod[66:31];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mop != MOP_NONE) begin
            r_prod <= mul_a * mul_b;
        end
        case (i_cmd.sop)
            SOP_ACC0:  r_acc   <= r_prod[63:0];
            SOP_ACC:   r_acc   <= r_acc + r_prod[63:0];
            SOP_OB: begin
                case (i_cmd.ssel)
                    2'd0:    r_ox <= r_prod[67:32];
                    2'd1:    r_oy <= r_prod[67:32];
                    default: r_oz <= r_prod[67:32];
                endcase
            end
            SOP_RAD32: r_rad   <= r_prod[65:32];
            SOP_RAD31: r_rad   <= r_prod[64:31];
            SOP_MINOR: r_minor <= r_prod[65:32];
            SOP_RING:  r_rad   <= {3'b000, r_width[31:1]} + r_prod[63:30];
            SOP_OX:    r_ox    <= r_prod[65:30];
            SOP_OY:    r_oy    <= r_prod[65:30];
            SOP_OZ:    r_oz    <= r_prod[65:30];
            SOP_OZH:   r_oz    <= (r_mode == MODE_INV_CONE) ? -oz_h : oz_h;
            default: ;
        endcase
        if (i_cmd.sop == SOP_DRAW) begin
            r_d0 <= r_d1;
            r_d1 <= r_d2;
            r_d2 <= n_gen;
        end
    end

    // generator and point index
    assign idx_inc = {1'b0, r_idx} + 17'd1;
    assign is_last = (idx_inc >= {1'b0, r_count});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= 31'd0;
            r_idx <= 16'd0;
        end else begin
            if (i_cmd.load && i_restart) begin
                r_gen <= i_seed;
                r_idx <= 16'd0;
            end else if (i_cmd.sop == SOP_DRAW) begin
                r_gen <= n_gen;
            end
            if (i_cmd.finish) begin
                r_idx <= is_last ? 16'd0 : idx_inc[15:0];
            end
        end
    end

    // bitwise square root, one result bit per cycle
    assign sq_try = r_sq_res + r_sq_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_bit <= 64'd0;
        end else if (i_cmd.sq_start) begin
            r_sq_bit <= 64'h4000_0000_0000_0000;
        end else if (|r_sq_bit) begin
            r_sq_bit <= r_sq_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_start) begin
            r_sq_n   <= {2'b00, d_sq, 31'd0};
            r_sq_res <= 64'd0;
        end else if (|r_sq_bit) begin
            if (r_sq_n >= sq_try) begin
                r_sq_n   <= r_sq_n - sq_try;
                r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
        end
    end

    // cordic rotation, one micro-rotation per cycle
    assign dx   = r_cy >>> r_cd_cnt;
    assign dy   = r_cx >>> r_cd_cnt;
    assign atan = {4'b0000, atan_turn(5'(r_cd_cnt))};

    always_comb begin
        if (!r_cz[33]) begin
            n_cx = r_cx - dx;
            n_cy = r_cy + dy;
            n_cz = r_cz - atan;
        end else begin
            n_cx = r_cx + dx;
            n_cy = r_cy - dy;
            n_cz = r_cz + atan;
        end
        case (r_quad)
            2'd0: begin
                q_c = n_cx;
                q_s = n_cy;
            end
            2'd1: begin
                q_c = -n_cy;
                q_s = n_cx;
            end
            2'd2: begin
                q_c = -n_cx;
                q_s = -n_cy;
            end
            default: begin
                q_c = n_cy;
                q_s = -n_cx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd_busy <= 1'b0;
            r_cd_cnt  <= '0;
        end else if (i_cmd.cd_start) begin
            r_cd_busy <= 1'b1;
            r_cd_cnt  <= '0;
        end else if (r_cd_busy) begin
            if (r_cd_cnt == CntW'(TRIG_ITERATIONS - 1)) begin
                r_cd_busy <= 1'b0;
            end else begin
                r_cd_cnt <= r_cd_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cd_start) begin
            r_cx     <= 34'(CORDIC_GAIN);
            r_cy     <= '0;
            r_cz     <= {4'b0000, d_cd[28:0], 1'b0};
            r_quad   <= d_cd[30:29];
            r_cd_dst <= i_cmd.cd_dst;
        end else if (r_cd_busy) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_cz <= n_cz;
            if (r_cd_cnt == CntW'(TRIG_ITERATIONS - 1)) begin
                if (r_cd_dst) begin
                    r_c2 <= q_c;
                    r_s2 <= q_s;
                end else begin
                    r_c1 <= q_c;
                    r_s1 <= q_s;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_px   <= sat32($signed({{5{r_cen_x[31]}}, r_cen_x}) + 37'(r_ox));
            r_py   <= sat32($signed({{5{r_cen_y[31]}}, r_cen_y}) + 37'(r_oy));
            r_pz   <= sat32($signed({{5{r_cen_z[31]}}, r_cen_z}) + 37'(r_oz));
            r_last <= is_last;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_px;
    assign o_y     = r_py;
    assign o_z     = r_pz;
    assign o_last  = r_last;

    assign o_stat.shape    = shape_of(r_mode);
    assign o_stat.ball_ok  = (r_acc <= 64'h4000_0000_0000_0000)
                             && ((r_mode != MODE_HEMI) || !c_z[33]);
    assign o_stat.sq_busy  = |r_sq_bit;
    assign o_stat.cd_busy  = r_cd_busy;
    assign o_stat.out_full = r_valid && !i_ready;

    a_sq_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sq_start |-> !(|r_sq_bit))
        else $error("sqrt restarted while busy");

    a_cd_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cd_start |-> !r_cd_busy)
        else $error("cordic restarted while busy");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !(r_valid && !i_ready))
        else $error("result overwritten before taken");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_valid)
        else $error("finished point not presented");

    a_sq_bit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_sq_bit))
        else $error("sqrt bit pointer corrupted");

endmodule

// ===== rtl/core/shape_point_sampler.sv =====
// Path from accepting edge to registered point: sphere/hemisphere repeats three LCG draws and
//   a squared-norm test per rejected attempt; cylinder/cone time is set by the 32-step sqrt;
//   torus time is set by two CORDIC passes in series.
// Requests: one at a time; the next is taken the cycle after the point is registered, and
//   it may be taken while that point still waits.
// Reset: synchronous active-low; clears generator, point index, output valid; config to defaults.
module shape_point_sampler
    import sps_pkg::*;
#(
    parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [0] restart, [31:1] seed
    // point stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [31:0] point_x, [63:32] point_y, [95:64] point_z
    output logic        m_axis_tlast,   // last_point
    // register writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data
);

    t_cmd        cmd;
    t_stat       stat;
    logic [31:0] px, py, pz;

    // controller sequences draws, multiplier slots and the sqrt/CORDIC units
    sps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath: LCG, shared 34x34 multiplier, sqrt, CORDIC, output register
    sps_dp #(
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_restart  (s_axis_tdata[0]),
        .i_seed     (s_axis_tdata[31:1]),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_x        (px),
        .o_y        (py),
        .o_z        (pz),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {pz, py, px};

endmodule
